FILE: hw/rtl/ppw_pkg.sv
// Package for the periodic polyline wrapper: widths, types and saturation helpers.
`timescale 1ns / 1ps
package ppw_pkg;
    localparam int FRAC_BITS = 16;
    localparam int TBITS     = 30;
    localparam int COORD_W   = 32;
    localparam int SHIFT_W   = 16;
    localparam int WIDE_W    = COORD_W + 2;
    localparam int T_W       = TBITS + 1;
    localparam int AXES_W    = 3;
    localparam int IN_W      = 3 * COORD_W;
    localparam int OUT_W     = 6 * COORD_W;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [SHIFT_W-1:0] shift_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;

    localparam logic signed [63:0] CMAX = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
    localparam logic signed [63:0] CMIN = -(64'sd1 <<< (COORD_W - 1));
    localparam logic signed [63:0] SMAX = (64'sd1 <<< (SHIFT_W - 1)) - 64'sd1;
    localparam logic signed [63:0] SMIN = -(64'sd1 <<< (SHIFT_W - 1));

    function automatic coord_t sat_coord(input logic signed [63:0] v);
        coord_t r;
        if (v > CMAX) begin
            r = CMAX[COORD_W-1:0];
        end else if (v < CMIN) begin
            r = CMIN[COORD_W-1:0];
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    function automatic shift_t sat_shift(input logic signed [63:0] v);
        shift_t r;
        if (v > SMAX) begin
            r = SMAX[SHIFT_W-1:0];
        end else if (v < SMIN) begin
            r = SMIN[SHIFT_W-1:0];
        end else begin
            r = v[SHIFT_W-1:0];
        end
        return r;
    endfunction
endpackage

FILE: hw/rtl/periodic_polyline_wrapper.sv
// Periodic polyline wrapper: cuts polyline edges at periodic cell faces and folds the pieces.
//
// Usage: vertices enter on the s_ channel (s_tuser = line start, s_tdata = x, y, z in
// signed Q16.16). Pieces leave on the m_ channel, one item per piece, m_tlast on the last
// piece caused by a vertex, m_tuser set on the first piece after a line start or a wrap.
// cfg_wr_en/cfg_wr_data write the 3-bit periodic axis mask (reset 7); write only when idle.
// Sequence: one vertex at a time. A line start is stored and emits nothing. Another
// vertex is accepted, then runs up to 3 crossing rounds, then emits the final
// piece. A round scans 3 axes: an uncut axis whose edge crosses a face goes through
// setup, 31 divider steps and pick; a round with a crossing adds the multiply passes
// and an emit. Each axis is cut at most once, so the rounds test at most 3, 2 and 1
// axes. The block uses a shared restoring divider (one quotient bit per cycle, 31 bits
// per crossing test) and a shared 34x17 multiplier (two passes per axis).
// Output is one register deep: while the receiver stalls, the sequencer holds at the piece
// that is ready and s_tready stays low until the vertex is finished.
// Reset (aresetn low, synchronous) clears the open line, the shifts and the output valid.
`timescale 1ns / 1ps
module periodic_polyline_wrapper (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ppw_pkg::IN_W-1:0]     s_tdata,   // vert_x, vert_y, vert_z
    input  logic                         s_tuser,   // line_start
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ppw_pkg::OUT_W-1:0]    m_tdata,   // piece_x0, y0, z0, x1, y1, z1
    output logic                         m_tuser,   // after_break
    output logic                         m_tlast,   // last_piece
    input  logic                         cfg_wr_en,
    input  logic [ppw_pkg::AXES_W-1:0]   cfg_wr_data
);
    import ppw_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_DIV    = 4'd2;
    localparam logic [3:0] S_PICK   = 4'd3;
    localparam logic [3:0] S_MUL_LO = 4'd4;
    localparam logic [3:0] S_MUL_HI = 4'd5;
    localparam logic [3:0] S_CROSS  = 4'd6;
    localparam logic [3:0] S_EMIT   = 4'd7;
    localparam logic [3:0] S_FINAL  = 4'd8;

    localparam logic [1:0] LAST_AXIS = 2'd2;
    localparam logic [1:0] LAST_ITER = 2'd2;
    localparam logic [4:0] DIV_LAST  = 5'(T_W - 1);
    localparam int         HALF_T    = T_W / 2 + 1;
    localparam wide_t      ONE_W     = wide_t'(1) <<< FRAC_BITS;
    localparam logic signed [63:0] ONE_L = 64'sd1 <<< FRAC_BITS;

    logic [3:0]           state_reg;
    logic [AXES_W-1:0]    axes_reg;
    coord_t               prev_reg [3];
    shift_t               shift_reg [3];
    logic                 flag_reg;
    logic                 have_reg;
    coord_t               r1_reg [3];
    coord_t               r2_reg [3];
    coord_t               x_reg [3];
    logic [2:0]           done_reg;
    logic [1:0]           iter_reg;
    logic [1:0]           axis_reg;
    logic                 best_valid_reg;
    logic [1:0]           best_axis_reg;
    logic [T_W-1:0]       best_t_reg;
    wide_t                best_face_reg;
    logic                 best_up_reg;
    wide_t                cand_face_reg;
    logic                 cand_up_reg;
    logic [WIDE_W-2:0]    den_reg;
    logic [WIDE_W-2:0]    rem_reg;
    logic                 in_bit_reg;
    logic [T_W-1:0]       q_reg;
    logic [4:0]           div_cnt_reg;
    logic signed [63:0]   acc_reg;
    logic                 m_tvalid_reg;
    logic [OUT_W-1:0]     m_tdata_reg;
    logic                 m_tuser_reg;
    logic                 m_tlast_reg;

    // per-axis view of the current axis
    coord_t               r1a, r2a;
    coord_t               f1, f2;
    logic                 up, eligible;
    logic [FRAC_BITS-1:0] frac;
    wide_t                floor_w, face, diff;
    logic [FRAC_BITS:0]   num;
    logic [WIDE_W-2:0]    den;
    logic [WIDE_W-1:0]    trial;
    logic                 ge;
    logic [HALF_T-1:0]    tsel;
    logic signed [50:0]   prod;
    logic signed [63:0]   rnd;
    wide_t                xv;
    logic                 take;
    coord_t               xeff [3];
    logic                 nonzero;
    logic                 out_free;
    logic                 out_load;
    coord_t               vin [3];

    always_comb begin
        r1a      = r1_reg[axis_reg];
        r2a      = r2_reg[axis_reg];
        f1       = r1a >>> FRAC_BITS;
        f2       = r2a >>> FRAC_BITS;
        up       = f2 > f1;
        eligible = axes_reg[axis_reg] && !done_reg[axis_reg] && (f1 != f2);
        frac     = r1a[FRAC_BITS-1:0];
        floor_w  = wide_t'(signed'({r1a[COORD_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}}));
        face     = (up && frac != '0) ? floor_w + ONE_W : floor_w;
        if (up) begin
            num = (frac == '0) ? '0 : (FRAC_BITS + 1)'(ONE_W) - {1'b0, frac};
        end else begin
            num = {1'b0, frac};
        end
        diff  = wide_t'(r2a) - wide_t'(r1a);
        den   = diff[WIDE_W-1] ? (WIDE_W - 1)'(-diff) : diff[WIDE_W-2:0];
        trial = {rem_reg, in_bit_reg};
        ge    = trial >= {1'b0, den_reg};
        // low pass takes t[14:0], high pass t[30:15]
        tsel  = (state_reg == S_MUL_LO) ? {1'b0, best_t_reg[HALF_T-2:0]}
                                        : best_t_reg[T_W-1:HALF_T-1];
        prod  = diff * $signed({1'b0, tsel});
        rnd   = acc_reg + (64'sd1 <<< (TBITS - 1));
        xv    = wide_t'(r1a) + wide_t'(rnd >>> TBITS);
        take  = !best_valid_reg || (q_reg < best_t_reg);
        for (int i = 0; i < 3; i++) begin
            xeff[i] = (2'(i) == best_axis_reg) ? best_face_reg[COORD_W-1:0] : x_reg[i];
            vin[i]  = s_tdata[i*COORD_W +: COORD_W];
        end
        nonzero  = (xeff[0] != r1_reg[0]) || (xeff[1] != r1_reg[1]) || (xeff[2] != r1_reg[2]);
        out_free = !m_tvalid_reg || m_tready;
        out_load = out_free && (((state_reg == S_EMIT) && nonzero) || (state_reg == S_FINAL));
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            axes_reg       <= 3'b111;
            flag_reg       <= 1'b1;
            have_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
            iter_reg       <= '0;
            axis_reg       <= '0;
            done_reg       <= '0;
            div_cnt_reg    <= '0;
            for (int i = 0; i < 3; i++) begin
                prev_reg[i]  <= '0;
                shift_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                axes_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tuser || !have_reg) begin
                            for (int i = 0; i < 3; i++) begin
                                if (axes_reg[i]) begin
                                    prev_reg[i]  <= coord_t'({{(COORD_W-FRAC_BITS){1'b0}},
                                                             vin[i][FRAC_BITS-1:0]});
                                    shift_reg[i] <= sat_shift(-64'(vin[i] >>> FRAC_BITS));
                                end else begin
                                    prev_reg[i]  <= vin[i];
                                    shift_reg[i] <= '0;
                                end
                            end
                            flag_reg <= 1'b1;
                            have_reg <= 1'b1;
                        end else begin
                            for (int i = 0; i < 3; i++) begin
                                r1_reg[i] <= prev_reg[i];
                                r2_reg[i] <= sat_coord(64'(vin[i])
                                                       + (64'(shift_reg[i]) <<< FRAC_BITS));
                            end
                            done_reg       <= '0;
                            iter_reg       <= '0;
                            axis_reg       <= '0;
                            best_valid_reg <= 1'b0;
                            state_reg      <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (eligible) begin
                        den_reg       <= den;
                        rem_reg       <= (WIDE_W - 1)'(num >> 1);
                        in_bit_reg    <= num[0];
                        q_reg         <= '0;
                        div_cnt_reg   <= '0;
                        cand_face_reg <= face;
                        cand_up_reg   <= up;
                        state_reg     <= S_DIV;
                    end else if (axis_reg != LAST_AXIS) begin
                        axis_reg <= axis_reg + 2'd1;
                    end else begin
                        axis_reg  <= '0;
                        state_reg <= best_valid_reg ? S_MUL_LO : S_FINAL;
                    end
                end
                S_DIV: begin
                    rem_reg     <= ge ? (WIDE_W - 1)'(trial - {1'b0, den_reg})
                                      : trial[WIDE_W-2:0];
                    q_reg       <= {q_reg[T_W-2:0], ge};
                    in_bit_reg  <= 1'b0;
                    div_cnt_reg <= div_cnt_reg + 5'd1;
                    if (div_cnt_reg == DIV_LAST) begin
                        state_reg <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (take) begin
                        best_valid_reg <= 1'b1;
                        best_axis_reg  <= axis_reg;
                        best_t_reg     <= q_reg;
                        best_face_reg  <= cand_face_reg;
                        best_up_reg    <= cand_up_reg;
                    end
                    if (axis_reg != LAST_AXIS) begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= S_SCAN;
                    end else begin
                        axis_reg  <= '0;
                        state_reg <= S_MUL_LO;
                    end
                end
                S_MUL_LO: begin
                    acc_reg   <= 64'(prod);
                    state_reg <= S_MUL_HI;
                end
                S_MUL_HI: begin
                    acc_reg   <= acc_reg + (64'(prod) <<< (HALF_T - 1));
                    state_reg <= S_CROSS;
                end
                S_CROSS: begin
                    x_reg[axis_reg] <= xv[COORD_W-1:0];
                    if (axis_reg != LAST_AXIS) begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= S_MUL_LO;
                    end else begin
                        axis_reg  <= '0;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!nonzero || out_free) begin
                        if (nonzero) begin
                            m_tdata_reg  <= {xeff[2], xeff[1], xeff[0],
                                             r1_reg[2], r1_reg[1], r1_reg[0]};
                            m_tuser_reg  <= flag_reg;
                            m_tlast_reg  <= 1'b0;
                        end
                        // fold the remainder back by one cell on the cut axis
                        for (int i = 0; i < 3; i++) begin
                            r1_reg[i] <= (2'(i) == best_axis_reg)
                                       ? sat_coord(64'(best_face_reg)
                                                   - (best_up_reg ? ONE_L : -ONE_L))
                                       : xeff[i];
                        end
                        r2_reg[best_axis_reg] <= sat_coord(64'(r2_reg[best_axis_reg])
                                                  - (best_up_reg ? ONE_L : -ONE_L));
                        shift_reg[best_axis_reg] <= sat_shift(64'(shift_reg[best_axis_reg])
                                                  - (best_up_reg ? 64'sd1 : -64'sd1));
                        done_reg[best_axis_reg] <= 1'b1;
                        flag_reg       <= 1'b1;
                        best_valid_reg <= 1'b0;
                        axis_reg       <= '0;
                        if (iter_reg == LAST_ITER) begin
                            state_reg <= S_FINAL;
                        end else begin
                            iter_reg  <= iter_reg + 2'd1;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_FINAL: begin
                    if (out_free) begin
                        m_tdata_reg  <= {r2_reg[2], r2_reg[1], r2_reg[0],
                                         r1_reg[2], r1_reg[1], r1_reg[0]};
                        m_tuser_reg  <= flag_reg;
                        m_tlast_reg  <= 1'b1;
                        flag_reg     <= 1'b0;
                        for (int i = 0; i < 3; i++) begin
                            prev_reg[i] <= r2_reg[i];
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_tready) else $error("ready while busy");
    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (div_cnt_reg <= DIV_LAST)) else $error("divider overrun");
    a_iter_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        iter_reg != 2'd3) else $error("too many crossing rounds");
    a_cut_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> !done_reg[best_axis_reg]) else $error("axis cut twice");
    a_emit_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> best_valid_reg) else $error("emit without crossing");
`endif
endmodule

FILE: dv/tb_periodic_polyline_wrapper.sv
// Self-checking testbench for periodic_polyline_wrapper: random and directed polylines.
`timescale 1ns / 1ps
module tb_periodic_polyline_wrapper;
    import ppw_pkg::*;

    localparam longint ONE = 64'sd1 <<< FRAC_BITS;

    typedef struct {
        logic [OUT_W-1:0] data;
        bit               brk;
        bit               last;
    } piece_t;

    class piece_scoreboard;
        piece_t       pending[$];
        int           errors;
        bit [2:0]     axes;
        longint       prev_pt[3];
        longint       img_shift[3];
        bit           brk_next;
        bit           line_open;

        function new();
            axes = 3'd7;
            brk_next = 1'b1;
            line_open = 1'b0;
            errors = 0;
            for (int i = 0; i < 3; i++) begin
                prev_pt[i] = 0;
                img_shift[i] = 0;
            end
        endfunction

        function longint clip(longint v, longint hi, longint lo);
            return v > hi ? hi : (v < lo ? lo : v);
        endfunction

        function void push_piece(longint a[3], longint b[3], bit last);
            piece_t p;
            p.data = {b[2][31:0], b[1][31:0], b[0][31:0], a[2][31:0], a[1][31:0], a[0][31:0]};
            p.brk  = brk_next;
            p.last = last;
            pending.insert(pending.size(), p);
            brk_next = 1'b0;
        endfunction

        // Cuts the edge from the previous point at periodic faces and queues the pieces.
        function void note_vertex(bit line_start, coord_t vx, coord_t vy, coord_t vz);
            longint v[3], r1[3], r2[3], x[3];
            bit done[3];
            int best;
            longint unsigned num, den, t, best_t;
            longint f1, f2, face, dir, best_face, best_dir, prod;
            v[0] = vx;
            v[1] = vy;
            v[2] = vz;
            done = '{0, 0, 0};
            if (line_start || !line_open) begin
                for (int i = 0; i < 3; i++) begin
                    if (axes[i]) begin
                        f1 = v[i] >>> FRAC_BITS;
                        prev_pt[i] = v[i] - f1 * ONE;
                        img_shift[i] = clip(-f1, 32767, -32768);
                    end else begin
                        prev_pt[i] = v[i];
                        img_shift[i] = 0;
                    end
                end
                brk_next = 1'b1;
                line_open = 1'b1;
                return;
            end
            for (int i = 0; i < 3; i++) begin
                r1[i] = prev_pt[i];
                r2[i] = clip(v[i] + img_shift[i] * ONE, 64'sd2147483647, -64'sd2147483648);
            end
            for (int it = 0; it < 3; it++) begin
                best = -1;
                best_t = 0;
                best_face = 0;
                best_dir = 0;
                for (int i = 0; i < 3; i++) begin
                    if (!axes[i] || done[i]) continue;
                    f1 = r1[i] >>> FRAC_BITS;
                    f2 = r2[i] >>> FRAC_BITS;
                    if (f1 == f2) continue;
                    if (f2 > f1) begin
                        face = -((-r1[i]) >>> FRAC_BITS) * ONE;
                        dir = 1;
                    end else begin
                        face = f1 * ONE;
                        dir = -1;
                    end
                    num = (face - r1[i]) < 0 ? r1[i] - face : face - r1[i];
                    den = (r2[i] - r1[i]) < 0 ? r1[i] - r2[i] : r2[i] - r1[i];
                    if (den == 0) continue;
                    t = (num << TBITS) / den;
                    if (best < 0 || t < best_t) begin
                        best = i;
                        best_t = t;
                        best_face = face;
                        best_dir = dir;
                    end
                end
                if (best < 0) break;
                for (int i = 0; i < 3; i++) begin
                    prod = longint'(best_t) * (r2[i] - r1[i]);
                    x[i] = r1[i] + ((prod + (64'sd1 <<< (TBITS - 1))) >>> TBITS);
                end
                x[best] = best_face;
                // zero-length crossing pieces are dropped
                if (x[0] != r1[0] || x[1] != r1[1] || x[2] != r1[2])
                    push_piece(r1, x, 1'b0);
                img_shift[best] = clip(img_shift[best] - best_dir, 32767, -32768);
                r1 = x;
                r1[best] = clip(r1[best] - best_dir * ONE, 64'sd2147483647, -64'sd2147483648);
                r2[best] = clip(r2[best] - best_dir * ONE, 64'sd2147483647, -64'sd2147483648);
                brk_next = 1'b1;
                done[best] = 1'b1;
            end
            push_piece(r1, r2, 1'b1);
            prev_pt = r2;
        endfunction

        function void check_piece(logic [OUT_W-1:0] data, logic brk, logic last);
            piece_t e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected piece %h brk=%b last=%b", data, brk, last);
                return;
            end
            e = pending.pop_front();
            if (data !== e.data || brk !== e.brk || last !== e.last) begin
                errors++;
                if (errors <= 10)
                    $display("piece: exp %h brk=%b last=%b  got %h brk=%b last=%b",
                             e.data, e.brk, e.last, data, brk, last);
            end
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             s_tuser = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tuser;
    logic             m_tlast;
    logic             cfg_wr_en = 1'b0;
    logic [AXES_W-1:0] cfg_wr_data = '0;

    piece_scoreboard sb = new();
    bit              steady = 1'b0;
    coord_t          last_v[3];

    always #1 aclk = ~aclk;

    periodic_polyline_wrapper i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_piece(m_tdata, m_tuser, m_tlast);
        m_tready <= steady || ($urandom_range(99) >= 6);
    end

    task automatic send_vertex(bit ls, coord_t x, coord_t y, coord_t z);
        while (!steady && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ls;
        s_tdata  <= {z, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_vertex(ls, x, y, z);
        last_v = '{x, y, z};
    endtask

    task automatic set_axes(bit [2:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        // a line start leaves no piece to wait for; let the block settle
        repeat (400) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.axes = value;
    endtask

    function automatic coord_t near_coord(coord_t base);
        coord_t d;
        d = $urandom_range(0, 6 << 16) - (3 << 16);
        if ($urandom_range(99) < 15) d = d & ~32'hFFFF;
        return base + d;
    endfunction

    function automatic coord_t any_coord();
        return $urandom_range(99) < 25 ? coord_t'($urandom()) : near_coord(0);
    endfunction

    task automatic random_line(inout int sent);
        int n;
        n = $urandom_range(1, 6);
        if ($urandom_range(99) < 10)
            send_vertex(1'b0, any_coord(), any_coord(), any_coord());
        else
            send_vertex(1'b1, any_coord(), any_coord(), any_coord());
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 8)
                send_vertex(1'b0, any_coord(), any_coord(), any_coord());
            else
                send_vertex(1'b0, near_coord(last_v[0]), near_coord(last_v[1]),
                            near_coord(last_v[2]));
        end
        sent += n + 1;
    endtask

    initial begin
        bit [2:0] phases[8];
        int sent;
        phases = '{3'd0, 3'd5, 3'd2, 3'd7, 3'd1, 3'd6, 3'd3, 3'd4};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        set_axes(3'd7);
        // no open line: treated as a start
        send_vertex(1'b0, 32'h8000, 32'h8000, 32'h8000);
        send_vertex(1'b0, 32'h30100, 32'h8000, 32'h8000);
        send_vertex(1'b0, -32'h10000, -32'h28000, 32'h18000);
        // start on integer faces, then move off them up and down
        send_vertex(1'b1, 32'h10000, 32'h20000, 32'h0);
        send_vertex(1'b0, 32'h18000, -32'h4000, 32'h8000);
        send_vertex(1'b0, 32'h28000, 32'h8000, -32'h4000);
        // exact corner tie across all axes
        send_vertex(1'b1, 32'h0, 32'h0, 32'h0);
        send_vertex(1'b0, 32'h10000, 32'h10000, 32'h10000);
        send_vertex(1'b1, -32'h1, -32'h1, -32'h1);
        send_vertex(1'b0, 32'h0, 32'h0, 32'h0);
        // shift and coordinate saturation
        send_vertex(1'b1, 32'h80000000, 32'h7FFFFFFF, 32'h0);
        send_vertex(1'b0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFF);
        send_vertex(1'b0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        send_vertex(1'b1, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send_vertex(1'b0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        foreach (phases[p]) begin
            set_axes(phases[p]);
            steady = (p == 3);
            sent = 0;
            while (sent < 36) begin
                random_line(sent);
            end
            if (p == 4) begin
                // cfg_wr_en held low with a line open, so the axis mask is not written here
                cfg_wr_en <= 1'b0;
            end
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("periodic_polyline_wrapper: match");
        end else begin
            $display("periodic_polyline_wrapper: mismatch");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("periodic_polyline_wrapper: mismatch");
        $finish;
    end
endmodule
